// ===== rtl/tournament_top_bottom_select_core_macros.svh =====
// Assertion helpers for the checker file ttbs_checker.sv.
`ifndef TOURNAMENT_TOP_BOTTOM_SELECT_CORE_MACROS_SVH
`define TOURNAMENT_TOP_BOTTOM_SELECT_CORE_MACROS_SVH

// Checked only while out of reset.
`define TTBS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ttbs assertion failed");

// Checked at every edge, reset included.
`define TTBS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ttbs assertion failed");

`endif

// ===== rtl/ttbs_pkg.sv =====
package ttbs_pkg;

    localparam int IDX_W = 11;
    localparam int FIT_W = 16;
    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(10);

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [FIT_W-1:0] score;
    } t_slot;

endpackage

// ===== rtl/tournament_top_bottom_select_core.sv =====
// channel | signals                                        | direction
// --------+------------------------------------------------+----------
// in      | i_in_valid, o_in_ready, i_entrant_*            | entrant in
// out     | o_out_valid, i_out_ready, o_*_index            | selection out
// cfg     | i_cfg_wr_en, i_cfg_wr_data                     | size write
//
// One item per cycle unless a result stalls; o_out_valid is registered.
// The input register is worked on whenever the result register is empty or
// being taken, so a stalled result blocks only a held input item.
// Synchronous active-low reset clears all slots, the count and sets size to 10.
module tournament_top_bottom_select_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [ttbs_pkg::CNT_W-1:0]  i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ttbs_pkg::IDX_W-1:0]  i_entrant_index,
    input  logic [ttbs_pkg::FIT_W-1:0]  i_entrant_fitness,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ttbs_pkg::IDX_W-1:0]  o_best_index,
    output logic [ttbs_pkg::IDX_W-1:0]  o_second_index,
    output logic [ttbs_pkg::IDX_W-1:0]  o_second_worst_index,
    output logic [ttbs_pkg::IDX_W-1:0]  o_worst_index
);

    logic [ttbs_pkg::CNT_W-1:0] r_size;
    logic                       r_in_valid;
    ttbs_pkg::t_slot            r_in;
    ttbs_pkg::t_slot            r_best, r_runner, r_low, r_near;
    ttbs_pkg::t_slot            n_best, n_runner, n_low, n_near;
    logic [ttbs_pkg::CNT_W-1:0] r_cnt;
    logic [ttbs_pkg::CNT_W-1:0] n_cnt;
    logic                       r_out_valid;
    logic [ttbs_pkg::IDX_W-1:0] r_out_best, r_out_runner, r_out_near, r_out_low;

    logic proc;
    logic dup;
    logic emit;

    assign proc       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc;

    always_comb begin
        dup = (r_cnt >= ttbs_pkg::CNT_W'(1) && r_in.idx == r_best.idx)
           || (r_cnt >= ttbs_pkg::CNT_W'(2) && r_in.idx == r_runner.idx)
           || (r_cnt >= ttbs_pkg::CNT_W'(3) && r_in.idx == r_low.idx)
           || (r_cnt >= ttbs_pkg::CNT_W'(4) && r_in.idx == r_near.idx);

        n_best   = r_best;
        n_runner = r_runner;
        n_low    = r_low;
        n_near   = r_near;
        if (r_cnt == ttbs_pkg::CNT_W'(0)) begin
            n_best = r_in;
        end else if (r_cnt == ttbs_pkg::CNT_W'(1)) begin
            n_runner = r_in;
        end else if (r_cnt == ttbs_pkg::CNT_W'(2)) begin
            n_low = r_in;
        end else if (r_cnt == ttbs_pkg::CNT_W'(3)) begin
            n_near = r_in;
        end else if (r_best.score < r_in.score) begin
            n_runner = r_best;
            n_best   = r_in;
        end else if (r_runner.score < r_in.score) begin
            n_runner = r_in;
        end else if (r_low.score > r_in.score) begin
            n_near = r_low;
            n_low  = r_in;
        end else if (r_near.score > r_in.score) begin
            n_near = r_in;
        end

        n_cnt = r_cnt + ttbs_pkg::CNT_W'(1);
        emit  = n_cnt >= r_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= ttbs_pkg::SIZE_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_best      <= '0;
            r_runner    <= '0;
            r_low       <= '0;
            r_near      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end

            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end

            if (proc && !dup && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (proc && !dup) begin
                if (emit) begin
                    r_cnt    <= '0;
                    r_best   <= '0;
                    r_runner <= '0;
                    r_low    <= '0;
                    r_near   <= '0;
                end else begin
                    r_cnt    <= n_cnt;
                    r_best   <= n_best;
                    r_runner <= n_runner;
                    r_low    <= n_low;
                    r_near   <= n_near;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.idx   <= i_entrant_index;
            r_in.score <= i_entrant_fitness;
        end
        if (proc && !dup && emit) begin
            r_out_best   <= n_best.idx;
            r_out_runner <= n_runner.idx;
            r_out_near   <= n_near.idx;
            r_out_low    <= n_low.idx;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_best_index         = r_out_best;
    assign o_second_index       = r_out_runner;
    assign o_second_worst_index = r_out_near;
    assign o_worst_index        = r_out_low;

endmodule

// ===== rtl/ttbs_checker.sv =====
`include "tournament_top_bottom_select_core_macros.svh"

module ttbs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [ttbs_pkg::IDX_W-1:0]  o_best_index,
    input logic [ttbs_pkg::IDX_W-1:0]  o_worst_index
);

    // no result pending means the input side is never blocked
    `TTBS_ASSERT(a_ready_when_out_empty, !o_out_valid |-> o_in_ready)

    // input can only be blocked by an item taken earlier and still held
    `TTBS_ASSERT(a_block_needs_item, !o_in_ready |-> $past(i_in_valid || !o_in_ready))

    // no result right after reset
    `TTBS_ASSERT(a_out_clear_after_rst, $past(!i_rst_n) |-> !o_out_valid)

    // a stalled result holds its valid and its best and worst indices
    `TTBS_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid)
    `TTBS_ASSERT(a_out_data, o_out_valid && !i_out_ready |=> $stable({o_best_index, o_worst_index}))

endmodule

bind tournament_top_bottom_select_core ttbs_checker u_ttbs_checker (.*);

// ===== sim/ttbs_selection_checker.sv =====
module ttbs_selection_checker
    import ttbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [IDX_W-1:0] i_entrant_index,
    input  logic [FIT_W-1:0] i_entrant_fitness,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [IDX_W-1:0] i_best_index,
    input  logic [IDX_W-1:0] i_second_index,
    input  logic [IDX_W-1:0] i_second_worst_index,
    input  logic [IDX_W-1:0] i_worst_index,
    output int               o_pending,
    output int               o_fails,
    output int               o_selections,
    output int               o_repeats
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0] best;
        logic [IDX_W-1:0] second;
        logic [IDX_W-1:0] second_worst;
        logic [IDX_W-1:0] worst;
    } t_selection;

    t_slot            best_q;
    t_slot            runner_q;
    t_slot            low_q;
    t_slot            near_low_q;
    logic [CNT_W-1:0] entrant_count;
    logic [CNT_W-1:0] tour_size;
    t_selection       selections_due[$];
    t_selection       want;

    task automatic clear_tournament();
        best_q        = '0;
        runner_q      = '0;
        low_q         = '0;
        near_low_q    = '0;
        entrant_count = '0;
    endtask

    task automatic score_entrant(input logic [IDX_W-1:0] idx, input logic [FIT_W-1:0] fit);
        t_slot cand;
        logic  repeat_hit;
        cand.idx   = idx;
        cand.score = fit;
        // only slots already filled take part in the repeat check
        repeat_hit = (entrant_count >= 1 && idx == best_q.idx) ||
                     (entrant_count >= 2 && idx == runner_q.idx) ||
                     (entrant_count >= 3 && idx == low_q.idx) ||
                     (entrant_count >= 4 && idx == near_low_q.idx);
        if (repeat_hit) begin
            o_repeats++;
            return;
        end
        case (entrant_count)
            0: best_q = cand;
            1: runner_q = cand;
            2: low_q = cand;
            3: near_low_q = cand;
            default: begin
                if (best_q.score < fit) begin
                    runner_q = best_q;
                    best_q   = cand;
                end else if (runner_q.score < fit) begin
                    runner_q = cand;
                end else if (low_q.score > fit) begin
                    near_low_q = low_q;
                    low_q      = cand;
                end else if (near_low_q.score > fit) begin
                    near_low_q = cand;
                end
            end
        endcase
        entrant_count = entrant_count + 1'b1;
        if (entrant_count >= tour_size) begin
            selections_due.push_back('{best_q.idx, runner_q.idx, near_low_q.idx, low_q.idx});
            clear_tournament();
        end
    endtask

    task automatic check_field(input string name, input logic [IDX_W-1:0] exp_val,
                               input logic [IDX_W-1:0] got_val);
        if (exp_val !== got_val) begin
            o_fails++;
            if (o_fails <= 10)
                $display("tb: %s mismatch, expected %0d, got %0d", name, exp_val, got_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tournament();
            tour_size = SIZE_RESET;
            selections_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (selections_due.size() == 0) begin
                    o_fails++;
                    if (o_fails <= 10)
                        $display("tb: unexpected selection best=%0d second=%0d",
                                 i_best_index, i_second_index);
                end else begin
                    want = selections_due.pop_front();
                    check_field("best_index", want.best, i_best_index);
                    check_field("second_index", want.second, i_second_index);
                    check_field("second_worst_index", want.second_worst, i_second_worst_index);
                    check_field("worst_index", want.worst, i_worst_index);
                    o_selections++;
                end
            end
            if (i_cfg_wr_en)
                tour_size = i_cfg_wr_data;
            if (i_in_valid && i_in_ready)
                score_entrant(i_entrant_index, i_entrant_fitness);
        end
        o_pending <= selections_due.size();
    end

endmodule

// ===== sim/tb_tournament_top_bottom_select_core.sv =====
module tb_tournament_top_bottom_select_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ttbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_PHASES  = 16;
    localparam int PHASE_ITEMS    = 95;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [CNT_W-1:0] i_cfg_wr_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [IDX_W-1:0] i_entrant_index = '0;
    logic [FIT_W-1:0] i_entrant_fitness = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [IDX_W-1:0] o_best_index;
    logic [IDX_W-1:0] o_second_index;
    logic [IDX_W-1:0] o_second_worst_index;
    logic [IDX_W-1:0] o_worst_index;

    int pending;
    int fails;
    int selections;
    int repeats;
    int sent_count = 0;
    int size_writes = 0;
    int stall_cycles = 0;
    bit steady_flow = 1'b0;

    tournament_top_bottom_select_core u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_entrant_index     (i_entrant_index),
        .i_entrant_fitness   (i_entrant_fitness),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_best_index        (o_best_index),
        .o_second_index      (o_second_index),
        .o_second_worst_index(o_second_worst_index),
        .o_worst_index       (o_worst_index)
    );

    ttbs_selection_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_entrant_index     (i_entrant_index),
        .i_entrant_fitness   (i_entrant_fitness),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_best_index        (o_best_index),
        .i_second_index      (o_second_index),
        .i_second_worst_index(o_second_worst_index),
        .i_worst_index       (o_worst_index),
        .o_pending           (pending),
        .o_fails             (fails),
        .o_selections        (selections),
        .o_repeats           (repeats)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady_flow || ($urandom_range(99) >= 30);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !(i_in_valid && o_in_ready) && !(o_out_valid && i_out_ready))
            stall_cycles <= stall_cycles + 1;
        else
            stall_cycles <= 0;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_entrant(input logic [IDX_W-1:0] idx, input logic [FIT_W-1:0] fit);
        while (!steady_flow && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_entrant_index   <= idx;
        i_entrant_fitness <= fit;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
    endtask

    // hold the input until every selection is out, then let the pipeline empty
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [CNT_W-1:0] size_val);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= size_val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        size_writes++;
    endtask

    initial begin
        int               size_pick;
        int               roll;
        logic [IDX_W-1:0] idx;
        logic [FIT_W-1:0] fit;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size of 10: fills, repeats, displacement, ties
        send_entrant(5, 100);
        send_entrant(5, 200);
        send_entrant(2047, 65535);
        send_entrant(0, 0);
        send_entrant(7, 50);
        send_entrant(0, 10);
        send_entrant(9, 300);
        send_entrant(2047, 150);
        send_entrant(11, 0);
        send_entrant(12, 300);
        send_entrant(13, 0);
        send_entrant(14, 40000);

        // sizes below four leave slots unfilled
        set_size(1);
        send_entrant(3, 9);
        send_entrant(3, 9);
        set_size(0);
        send_entrant(2047, 65535);
        send_entrant(0, 0);
        set_size(2);
        send_entrant(100, 5);
        send_entrant(100, 6);
        send_entrant(101, 7);
        set_size(3);
        send_entrant(200, 1);
        send_entrant(201, 65535);
        send_entrant(202, 1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: size_pick = 4;
                1: size_pick = 63;
                2: size_pick = 5;
                default: begin
                    roll = $urandom_range(99);
                    if (roll < 70)
                        size_pick = $urandom_range(12, 4);
                    else if (roll < 85)
                        size_pick = $urandom_range(3, 0);
                    else
                        size_pick = $urandom_range(63, 13);
                end
            endcase
            set_size(CNT_W'(size_pick));
            steady_flow <= (phase == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(3))
                    0: idx = IDX_W'($urandom);
                    1, 2: idx = IDX_W'($urandom_range(15));
                    default: idx = $urandom_range(1) ? '1 : '0;
                endcase
                case ($urandom_range(3))
                    0: fit = FIT_W'($urandom);
                    1: fit = FIT_W'($urandom_range(7));
                    2: fit = FIT_W'(16'hFFFF - $urandom_range(7));
                    default: fit = {8'($urandom_range(255)), 8'h00};
                endcase
                send_entrant(idx, fit);
            end
        end

        drain();
        $display("tb: %0d entrants sent, %0d ignored as repeats, %0d selections checked",
                 sent_count, repeats, selections);
        $display("tb: %0d size settings between 0 and 63, %0d mismatches",
                 size_writes, fails);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
